// File: hdl/sha_pkg.sv
package sha_pkg;

    // one input word and one digest word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // hash words, word 0 first
    typedef logic [7:0][31:0] t_hash;

    // control from the sequencer to the round core
    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       start;
        logic       init;
    } t_core_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_FINAL
    } t_core_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam t_hash HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// File: hdl/sha256_stream_hasher.sv
// SHA-256 over a byte stream.
// Input channel (i_in_valid / o_in_ready / i_in): one word per message byte;
// byte_valid marks a real byte, end_of_message closes the message (the last
// word may carry no byte, so an empty message works).
// Output channel (o_out_valid / i_out_ready / o_out): eight digest words,
// word 0 first, last_word set on word 7.
// A byte word is taken while the sequencer is idle. The 64th byte of a block
// starts the round core: 64 rounds at one per cycle, then a final step adds
// the working variables into the hash words. The input is held off while a
// block is compressed.
// After end_of_message the sequencer feeds the pad bytes into the window one
// per cycle (64 minus the bytes held, at most 72 over two blocks) with one or
// two more compressions, then shows the digest words one per accepted word.
// A stalled receiver holds the current digest word; no input is taken until
// word 7 is accepted, after which the hash words return to their initial
// values. Reset (synchronous, active low) gives the same fresh state.
module sha256_stream_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sha_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sha_pkg::t_out_item o_out
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bit_count, n_bit_count;
    logic [63:0] r_len, n_len;
    logic        r_pad_first, n_pad_first;
    logic        r_two_block, n_two_block;
    logic        r_eom, n_eom;
    logic        r_final, n_final;
    logic [2:0]  r_out_idx, n_out_idx;

    t_core_ctl   ctl;
    t_hash       hash;
    logic        core_done;
    logic        in_acc, out_acc;
    logic        len_byte;
    logic [7:0]  pad_byte;

    sha_round_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_hash  (hash),
        .o_done  (core_done)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    // pad byte: the 0x80 mark, zeros, then the bit length msb first
    always_comb begin
        len_byte = !r_pad_first && !r_two_block && (r_fill >= LEN_POS);
        if (r_pad_first) pad_byte = PAD_BYTE;
        else if (len_byte) pad_byte = r_len[63:56];
        else pad_byte = 8'h00;
    end

    // core control
    always_comb begin
        ctl.load  = (in_acc && i_in.byte_valid) || (r_state == ST_PAD);
        ctl.data  = (r_state == ST_PAD) ? pad_byte : i_in.data_byte;
        ctl.start = ctl.load && (r_fill == LAST_POS);
        ctl.init  = out_acc && (r_out_idx == LAST_IDX);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bit_count = r_bit_count;
        n_len       = r_len;
        n_pad_first = r_pad_first;
        n_two_block = r_two_block;
        n_eom       = r_eom;
        n_final     = r_final;
        n_out_idx   = r_out_idx;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_valid) begin
                        n_fill      = r_fill + 6'd1;
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (i_in.end_of_message) begin
                        n_len       = n_bit_count;
                        n_pad_first = 1'b1;
                        n_eom       = 1'b1;
                    end
                    if (ctl.start) begin
                        n_state = ST_COMP;
                        n_final = 1'b0;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_fill      = r_fill + 6'd1;
                n_pad_first = 1'b0;
                if (len_byte) n_len = {r_len[55:0], 8'h00};
                if (r_pad_first && (r_fill >= LEN_POS)) n_two_block = 1'b1;
                if (r_fill == LAST_POS) begin
                    n_state     = ST_COMP;
                    n_final     = !r_pad_first && !r_two_block;
                    n_two_block = 1'b0;
                end
            end
            ST_COMP: begin
                if (core_done) begin
                    if (r_final) begin
                        n_state   = ST_OUT;
                        n_final   = 1'b0;
                        n_out_idx = '0;
                    end else if (r_eom) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == LAST_IDX) begin
                        n_state     = ST_IDLE;
                        n_bit_count = '0;
                        n_fill      = '0;
                        n_eom       = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bit_count <= '0;
            r_pad_first <= 1'b0;
            r_two_block <= 1'b0;
            r_eom       <= 1'b0;
            r_final     <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bit_count <= n_bit_count;
            r_pad_first <= n_pad_first;
            r_two_block <= n_two_block;
            r_eom       <= n_eom;
            r_final     <= n_final;
            r_out_idx   <= n_out_idx;
        end
    end

    // length shifter
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    // digest word from the hash words, held while the receiver stalls
    always_comb begin
        o_out.digest_word = hash[r_out_idx];
        o_out.word_index  = r_out_idx;
        o_out.last_word   = (r_out_idx == LAST_IDX);
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while digest pending");

    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.byte_valid && (r_fill == LAST_POS)) |=> (r_state == ST_COMP))
        else $error("full block did not start compression");

    a_fresh_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last_word) |=> ((r_bit_count == 64'd0) && (r_fill == 6'd0)))
        else $error("message state not cleared after digest");

    a_pad_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> (r_eom && !o_in_ready))
        else $error("padding without end of message");
`endif

endmodule

// File: hdl/sha_round_core.sv
module sha_round_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    output sha_pkg::t_hash    o_hash,
    output logic              o_done
);
    import sha_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    t_core_state r_state, n_state;
    logic [5:0]  r_round;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    t_hash       r_hash;

    logic [31:0] big1, big0, ch, maj, t1, t2, w_new, s0, s1;

    // one round of the compression and one step of the schedule
    always_comb begin
        big1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        big0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big1 + ch + K_ROUND[r_round] + r_w[0];
        t2    = big0 + maj;
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
    end

    // round sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE: begin
                if (i_ctl.start) n_state = CS_ROUND;
            end
            CS_ROUND: begin
                if (r_round == LAST_POS) n_state = CS_FINAL;
            end
            CS_FINAL: begin
                n_state = CS_IDLE;
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == CS_ROUND) r_round <= r_round + 6'd1;
            else r_round <= '0;
        end
    end

    // hash words: initial values, then add the working variables per block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_hash <= HASH_INIT;
        end else if (r_state == CS_FINAL) begin
            for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (r_state == CS_IDLE && i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
        end else if (r_state == CS_ROUND) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // message window: bytes shift in, rounds shift the schedule
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            r_w[15] <= {r_w[15][23:0], i_ctl.data};
        end else if (r_state == CS_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    assign o_hash = r_hash;
    assign o_done = (r_state == CS_FINAL);

endmodule

// File: tb/sv/sha256_digest_checker.sv
`timescale 1ns / 1ps

module sha256_digest_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  sha_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sha_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    import sha_pkg::*;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam int         BLOCK_BYTES  = 64;
    localparam int         LEN_OFFSET   = 56;
    localparam int         REPORT_LIMIT = 10;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // running hash state of the message in flight
    logic [31:0] chain [8];
    logic [7:0]  msg_block [BLOCK_BYTES];
    logic [63:0] bits_done;
    int          block_fill;

    t_out_item   digest_due [$];
    int          mismatches = 0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into chain
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
        bits_done  = '0;
        block_fill = 0;
    endtask

    // take one accepted word; on the end mark, pad and queue the digest
    task automatic absorb_word(input t_in_item w);
        logic [63:0] msg_bits;
        t_out_item   dw;
        int          pos;
        if (w.byte_valid) begin
            msg_block[block_fill] = w.data_byte;
            block_fill++;
            if (block_fill == BLOCK_BYTES) begin
                compress_block();
                bits_done  = bits_done + 64'd512;
                block_fill = 0;
            end
        end
        if (w.end_of_message) begin
            msg_bits = bits_done + 64'(block_fill) * 64'd8;
            pos = block_fill;
            msg_block[pos] = PAD_MARK;
            pos++;
            // long tail: the length no longer fits, spill into a second block
            if (pos > LEN_OFFSET) begin
                while (pos < BLOCK_BYTES) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LEN_OFFSET) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int j = 0; j < 8; j++) msg_block[BLOCK_BYTES-1-j] = msg_bits[8*j +: 8];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                dw.digest_word = chain[j];
                dw.word_index  = 3'(j);
                dw.last_word   = (j == 7);
                digest_due.push_back(dw);
            end
            restart_message();
        end
    endtask

    // watch both channels, compare each digest word against the oldest due
    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            restart_message();
            for (int i = 0; i < BLOCK_BYTES; i++) msg_block[i] = 8'h00;
            digest_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("unexpected digest word %h index %0d last %0b",
                                 i_out.digest_word, i_out.word_index, i_out.last_word);
                    end
                    mismatches++;
                end else begin
                    due = digest_due.pop_front();
                    if (i_out.digest_word !== due.digest_word ||
                        i_out.word_index !== due.word_index ||
                        i_out.last_word !== due.last_word) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display({"digest mismatch: expected %h idx %0d last %0b,",
                                      " got %h idx %0d last %0b"},
                                     due.digest_word, due.word_index, due.last_word,
                                     i_out.digest_word, i_out.word_index, i_out.last_word);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_word(i_in);
            end
        end
        o_pending    <= digest_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/sv/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
    import sha_pkg::*;

    localparam int ITEM_TARGET      = 310;
    localparam int MAX_GAP          = 8;
    localparam int LONG_HOLD_AT     = 20;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES    = 100;
    localparam int SHORT_MSG_MAX    = 24;
    localparam int EDGE_LEN [8]     = '{55, 56, 57, 63, 64, 65, 119, 120};

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_word;

    int        fail_count;
    int        pending;
    int        words_sent = 0;
    bit        sender_eager = 1'b0;

    always #2 clk = ~clk;

    sha256_stream_hasher i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    sha256_digest_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item word_of(input logic [7:0] b, input logic bv, input logic eom);
        t_in_item w;
        w.data_byte      = b;
        w.byte_valid     = bv;
        w.end_of_message = eom;
        return w;
    endfunction

    // offer one word after a random gap (none when the sender is eager), return once it is accepted
    task automatic send_word(input t_in_item w);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (w.byte_valid || w.end_of_message) words_sent++;
    endtask

    // sender goes quiet until every digest word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random bytes with stray empty words mixed in; end mark on the last byte or alone
    task automatic send_message(input int len, input bit empty_tail);
        sender_eager = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(word_of(8'($urandom), 1'b0, 1'b0));
            end
            send_word(word_of(8'($urandom), 1'b1, !empty_tail && (i == len - 1)));
        end
        if (empty_tail || len == 0) begin
            send_word(word_of(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    // digest receiver with random stalls and one long hold-off
    initial begin : digest_sink
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 8 == 0) eager = ($urandom_range(0, 2) == 0);
            if (taken == LONG_HOLD_AT) begin
                stall = LONG_HOLD_CYCLES;
            end else begin
                stall = eager ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        bit paused;
        paused = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty message, then words that carry nothing
        send_word(word_of(8'h00, 1'b0, 1'b1));
        send_word(word_of(8'hff, 1'b0, 1'b0));
        send_word(word_of(8'h00, 1'b0, 1'b0));
        // "abc", end mark with the last byte
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b0));
        send_word(word_of(8'h63, 1'b1, 1'b1));
        // extreme bytes closed by an empty final word
        send_word(word_of(8'hff, 1'b1, 1'b0));
        send_word(word_of(8'h00, 1'b1, 1'b0));
        send_word(word_of(8'h5a, 1'b0, 1'b1));
        // single-byte messages
        send_word(word_of(8'hff, 1'b1, 1'b1));
        send_word(word_of(8'h00, 1'b1, 1'b1));
        // empty word inside a message
        send_word(word_of(8'h12, 1'b1, 1'b0));
        send_word(word_of(8'hff, 1'b0, 1'b0));
        send_word(word_of(8'h34, 1'b1, 1'b1));
        // empty message with a junk byte on the final word
        send_word(word_of(8'hff, 1'b0, 1'b1));
        wait_drained();

        // random messages, mostly short, some across the block boundaries
        while (words_sent < ITEM_TARGET) begin
            if (!paused && words_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                len = EDGE_LEN[$urandom_range(0, 7)];
            end else begin
                len = $urandom_range(0, SHORT_MSG_MAX);
            end
            send_message(len, (len == 0) || ($urandom_range(0, 1) == 1));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_sha256_stream_hasher: done, clean");
        end else begin
            $display("tb_sha256_stream_hasher: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_sha256_stream_hasher: done, errors");
        $finish;
    end

endmodule
